// ----- src/mldec_pkg.sv -----
// Shared types and constants for the multilevel decimate-by-two block.
// Used by mldec_cfg and multilevel_decimate_by_two_top; no dependencies.
package mldec_pkg;

    localparam int LEVEL_W    = 4;
    localparam int CHANNEL_W  = 6;
    localparam int MODE_W     = 1;
    localparam int MAXLVL_W   = 4;
    localparam int KEEP_W     = 9;
    localparam int PPS_W      = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LEVELS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_SAMPLE = 2'd3;

    localparam logic MODE_AVERAGE = 1'b0;
    localparam logic MODE_MAXIMUM = 1'b1;

    localparam logic [MAXLVL_W-1:0] RST_MAX_LEVEL   = 4'd8;
    localparam logic [KEEP_W-1:0]   RST_KEEP_LEVELS = 9'h1ff;
    localparam logic [PPS_W-1:0]    RST_PPS         = 7'd1;

    typedef struct packed {
        logic                combine_mode;
        logic [MAXLVL_W-1:0] max_level;
        logic [KEEP_W-1:0]   keep_levels;
        logic [PPS_W-1:0]    points_per_sample;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } t_state;

endpackage

// ----- src/mldec_cfg.sv -----
// Configuration register file of the decimation pyramid.
// Depends on mldec_pkg for the register indexes, widths and reset values.
module mldec_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mldec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mldec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mldec_pkg::t_cfg                  o_cfg
);
    import mldec_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combine_mode      <= MODE_AVERAGE;
            r_cfg.max_level         <= RST_MAX_LEVEL;
            r_cfg.keep_levels       <= RST_KEEP_LEVELS;
            r_cfg.points_per_sample <= RST_PPS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COMBINE_MODE:      r_cfg.combine_mode      <= i_cfg_data[0];
                CFG_MAX_LEVEL:         r_cfg.max_level         <= i_cfg_data[MAXLVL_W-1:0];
                CFG_KEEP_LEVELS:       r_cfg.keep_levels       <= i_cfg_data[KEEP_W-1:0];
                CFG_POINTS_PER_SAMPLE: r_cfg.points_per_sample <= i_cfg_data[PPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/multilevel_decimate_by_two_top.sv -----
// Top level of the multilevel decimate-by-two pyramid: point walk and held-point memory.
// Depends on mldec_pkg and mldec_cfg.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_point_value
//   out      output     o_out_valid / i_out_ready o_level o_channel o_value o_last_result
//   cfg      input      i_cfg_we                  i_cfg_index i_cfg_data
//
// An item is taken in the idle state and then walks levels 0..T in the step state (T =
// first open pair or the level limit), level by level; the held-point memory gives
// one registered read per level, issued one level ahead of the combine.
// Reset is synchronous and clears phase, point counter, walk state and output valid.
// A stalled output holds the walk on a level that emits a result; the output
// register lets the next item transfer in while a result still waits.
module multilevel_decimate_by_two_top #(
    parameter int MAX_LEVELS   = 8,
    parameter int MAX_CHANNELS = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_point_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mldec_pkg::LEVEL_W-1:0]     o_level,
    output logic [mldec_pkg::CHANNEL_W-1:0]   o_channel,
    output logic signed [SAMPLE_WIDTH-1:0]    o_value,
    output logic                              o_last_result,
    input  logic                              i_cfg_we,
    input  logic [mldec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mldec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mldec_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LA_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int KW    = MAX_LEVELS + 1;
    localparam int AW    = LA_W + CH_W;
    localparam int DEPTH = 1 << AW;

    t_cfg cfg;

    mldec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_rdata;

    t_state                   r_state, n_state;
    logic [MAX_LEVELS-1:0]    r_phase, n_phase;
    logic [CH_W-1:0]          r_count, n_count;
    logic [SAMPLE_WIDTH-1:0]  r_val, n_val;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic [LVL_W-1:0]         r_lvl, n_lvl;
    logic [KW-1:0]            r_reach, n_reach;
    logic [KW-1:0]            r_kept, n_kept;

    logic                     r_o_valid, n_o_valid;
    logic [LEVEL_W-1:0]       r_o_level, n_o_level;
    logic [CHANNEL_W-1:0]     r_o_channel, n_o_channel;
    logic [SAMPLE_WIDTH-1:0]  r_o_value, n_o_value;
    logic                     r_o_last, n_o_last;

    logic [LVL_W-1:0]         lim;
    logic [KW-1:0]            lim_mask;
    logic [KW-1:0]            phase_low;
    logic [KW-1:0]            phase_inc;
    logic [KW+KEEP_W-1:0]     keep_wide;
    logic [KW-1:0]            keep_sh;
    logic [KW-1:0]            kept_above;
    logic [KW-1:0]            reach_above;
    logic                     sample_end;
    logic                     in_xfer;
    logic                     out_free;
    logic                     need_out;
    logic                     terminal;
    logic [SAMPLE_WIDTH:0]    pair_sum;
    logic [SAMPLE_WIDTH-1:0]  pair_val;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;

    always_comb begin
        if (32'(cfg.max_level) > MAX_LEVELS) begin
            lim = LVL_W'(MAX_LEVELS);
        end else begin
            lim = LVL_W'(cfg.max_level);
        end
        lim_mask  = (KW'(1) << lim) - KW'(1);
        phase_low = {1'b0, r_phase} & lim_mask;
        phase_inc = phase_low + KW'(1);
        keep_wide = {{KW{1'b0}}, cfg.keep_levels};
        sample_end = (32'(r_count) + 32'd1 >= 32'(cfg.points_per_sample)) ||
                     (32'(r_count) + 32'd1 >= MAX_CHANNELS);
    end

    always_comb begin
        pair_sum = {r_rdata[SAMPLE_WIDTH-1], r_rdata} + {r_val[SAMPLE_WIDTH-1], r_val};
        if (cfg.combine_mode == MODE_MAXIMUM) begin
            pair_val = ($signed(r_rdata) > $signed(r_val)) ? r_rdata : r_val;
        end else begin
            pair_val = pair_sum[SAMPLE_WIDTH:1];
        end
    end

    always_comb begin
        keep_sh     = r_kept >> r_lvl;
        kept_above  = r_kept >> (32'(r_lvl) + 32'd1);
        reach_above = r_reach >> (32'(r_lvl) + 32'd1);
        need_out    = keep_sh[0];
        terminal    = (reach_above == '0);
        out_free    = !r_o_valid || i_out_ready;
        in_xfer     = i_in_valid && (r_state == ST_IDLE);
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_val       = r_val;
        n_ch        = r_ch;
        n_lvl       = r_lvl;
        n_reach     = r_reach;
        n_kept      = r_kept;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_o_level   = r_o_level;
        n_o_channel = r_o_channel;
        n_o_value   = r_o_value;
        n_o_last    = r_o_last;
        rd_en       = 1'b0;
        rd_addr     = {LA_W'(0), r_count};
        wr_en       = 1'b0;
        wr_addr     = {LA_W'(r_lvl), r_ch};

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    rd_en   = 1'b1;
                    n_val   = i_point_value;
                    n_ch    = r_count;
                    n_lvl   = '0;
                    n_reach = phase_low ^ phase_inc;
                    n_kept  = (phase_low ^ phase_inc) & keep_wide[KW-1:0];
                    n_state = ST_STEP;
                    if (sample_end) begin
                        n_count = '0;
                        n_phase = (r_phase & ~lim_mask[MAX_LEVELS-1:0]) |
                                  (phase_inc[MAX_LEVELS-1:0] & lim_mask[MAX_LEVELS-1:0]);
                    end else begin
                        n_count = r_count + CH_W'(1);
                    end
                end
            end
            ST_STEP: begin
                if (!need_out || out_free) begin
                    if (need_out) begin
                        n_o_valid   = 1'b1;
                        n_o_level   = LEVEL_W'(r_lvl);
                        n_o_channel = CHANNEL_W'(r_ch);
                        n_o_value   = r_val;
                        n_o_last    = (kept_above == '0);
                    end
                    if (terminal) begin
                        wr_en   = (r_lvl < lim);
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {LA_W'(r_lvl + LVL_W'(1)), r_ch};
                        n_val   = pair_val;
                        n_lvl   = r_lvl + LVL_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_ch        <= n_ch;
        r_lvl       <= n_lvl;
        r_reach     <= n_reach;
        r_kept      <= n_kept;
        r_o_level   <= n_o_level;
        r_o_channel <= n_o_channel;
        r_o_value   <= n_o_value;
        r_o_last    <= n_o_last;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_level       = r_o_level;
    assign o_channel     = r_o_channel;
    assign o_value       = r_o_value;
    assign o_last_result = r_o_last;

endmodule
